@@ rtl/ccst_pkg.sv @@
// Shared types and constants for the coulomb-counting SOC tracker.
// No dependencies; used by every module of the block.
package ccst_pkg;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_LOAD   = 2'd2
	} op_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SUM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOC_GAIN = 2'd1;

	localparam int CFG_DATA_W = 24;
	localparam int ZERO_W     = 20;
	localparam int GAIN_W     = 24;
	localparam int SOC_W      = 31;

	localparam logic [ZERO_W-1:0] ZERO_SUM_RST = 20'd873600;
	localparam logic [GAIN_W-1:0] SOC_GAIN_RST = 24'd134208;
	localparam logic [SOC_W-1:0]  SOC_ONE      = 31'h4000_0000;

	typedef struct packed {
		logic sample_en;
		logic tick_en;
		logic load_en;
	} step_t;

endpackage

@@ rtl/coulomb_counting_soc_tracker_top.sv @@
// Top level of the coulomb-counting SOC tracker: input stage, config
// registers, ring and integrator. Depends on ccst_pkg, ccst_ring, ccst_charge.
//
// Usage:
//  s_* stream carries one request per item: tuser = operation (0 sample,
//  1 one-second tick, 2 load SOC); tdata = adc_sample, soc_value.
//  m_* stream returns one result per request: soc_now, window_total and
//  window_filled, the state right after that request.
//  cfg_* writes zero_sum (index 0) or soc_gain (index 1); always ready.
//  A request passes the input stage register, then the state registers
//  that drive m_tdata. One request per cycle is sustained while m_tready
//  is high: the direct update of sum and SOC and the prefetched ring read
//  allow this rate. When m_tready is low the result and state hold; one
//  more request enters the input stage if it is empty, then s_tready drops
//  until m_tready returns. Reset clears SOC, the window sum, pointer and
//  wrap flag and loads the config defaults; ring entries count as zero
//  until the first wrap, so no clearing pass is needed.
module coulomb_counting_soc_tracker_top #(
	parameter int WINDOW_DEPTH = 256,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// adc_sample, soc_value, zero pad
	input  logic [((SAMPLE_BITS + ccst_pkg::SOC_W + 7) / 8) * 8 - 1:0] s_tdata,
	// operation
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// soc_now, window_total, window_filled, zero pad
	output logic [((ccst_pkg::SOC_W + SAMPLE_BITS + $clog2(WINDOW_DEPTH) + 1 + 7) / 8) * 8 - 1:0]
		m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ccst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccst_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
	localparam int RES_W    = ccst_pkg::SOC_W + SUM_BITS + 1;
	localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

	logic                       valid_s1;
	logic [1:0]                 op_s1;
	logic [SAMPLE_BITS-1:0]     sample_s1;
	logic [ccst_pkg::SOC_W-1:0] soc_s1;
	logic                       m_valid_q;
	logic                       advance;
	logic                       fire;
	ccst_pkg::step_t            step;
	logic [ccst_pkg::ZERO_W-1:0] zero_q;
	logic [ccst_pkg::GAIN_W-1:0] gain_q;
	logic [SUM_BITS-1:0]        sum;
	logic                       wrapped;
	logic [ccst_pkg::SOC_W-1:0] soc;

	assign advance  = !m_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_valid_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= s_tuser;
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
			soc_s1    <= s_tdata[SAMPLE_BITS +: ccst_pkg::SOC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= ccst_pkg::ZERO_SUM_RST;
			gain_q <= ccst_pkg::SOC_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ccst_pkg::REG_ZERO_SUM: zero_q <= cfg_data[ccst_pkg::ZERO_W-1:0];
				ccst_pkg::REG_SOC_GAIN: gain_q <= cfg_data[ccst_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		step = '0;
		if (fire) begin
			case (op_s1)
				ccst_pkg::OP_SAMPLE: step.sample_en = 1'b1;
				ccst_pkg::OP_TICK:   step.tick_en   = 1'b1;
				ccst_pkg::OP_LOAD:   step.load_en   = 1'b1;
				default: ;
			endcase
		end
	end

	ccst_ring #(
		.DEPTH       (WINDOW_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_BITS    (SUM_BITS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.sample    (sample_s1),
		.sum_q     (sum),
		.wrapped_q (wrapped)
	);

	ccst_charge #(
		.SUM_BITS (SUM_BITS)
	) u_charge (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.sum        (sum),
		.zero_sum   (zero_q),
		.gain       (gain_q),
		.load_value (soc_s1),
		.soc_q      (soc)
	);

	// state registers hold while stalled, so they serve as the result register
	assign m_tdata = OUT_W'({wrapped, sum, soc});

endmodule

@@ rtl/ccst_ring.sv @@
// Sample ring, write pointer, running window sum and wrap flag.
// Depends on ccst_pkg (step_t).
module ccst_ring #(
	parameter int DEPTH       = 256,
	parameter int SAMPLE_BITS = 12,
	parameter int SUM_BITS    = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ccst_pkg::step_t        step,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SUM_BITS-1:0]    sum_q,
	output logic                   wrapped_q
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [PTR_W-1:0]       wp_q;
	logic [PTR_W-1:0]       wp_d;
	logic [SUM_BITS-1:0]    old_ext;
	logic [SUM_BITS-1:0]    new_ext;

	// entry at the pointer holds data only after the first wrap
	assign old_ext = wrapped_q ? SUM_BITS'(rd_q) : '0;
	assign new_ext = SUM_BITS'(sample);

	always_comb begin
		wp_d = wp_q;
		if (step.sample_en) begin
			wp_d = (wp_q == LAST) ? '0 : wp_q + PTR_W'(1);
		end
	end

	// prefetch the entry the next sample overwrites
	always_ff @(posedge clk) begin
		if (step.sample_en) begin
			mem[wp_q] <= sample;
		end
		rd_q <= mem[wp_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			sum_q     <= '0;
			wrapped_q <= 1'b0;
		end else begin
			wp_q <= wp_d;
			if (step.sample_en) begin
				sum_q <= sum_q - old_ext + new_ext;
				if (wp_q == LAST) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/ccst_charge.sv @@
// SOC integrator: tick update with gain and saturation, and direct load clamped to SOC_ONE.
// Depends on ccst_pkg (step_t, widths, SOC_ONE).
module ccst_charge #(
	parameter int SUM_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ccst_pkg::step_t               step,
	input  logic [SUM_BITS-1:0]           sum,
	input  logic [ccst_pkg::ZERO_W-1:0]   zero_sum,
	input  logic [ccst_pkg::GAIN_W-1:0]   gain,
	input  logic [ccst_pkg::SOC_W-1:0]    load_value,
	output logic [ccst_pkg::SOC_W-1:0]    soc_q
);

	localparam int BASE_W = (SUM_BITS > ccst_pkg::ZERO_W) ? SUM_BITS : ccst_pkg::ZERO_W;
	localparam int DIFF_W = BASE_W + 1;
	localparam int PROD_W = DIFF_W + ccst_pkg::GAIN_W + 1;
	localparam int DLT_W  = PROD_W - 16;
	localparam int MAX_W  = (DLT_W > ccst_pkg::SOC_W) ? DLT_W : ccst_pkg::SOC_W;
	localparam int NXT_W  = MAX_W + 2;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [DLT_W-1:0]  delta;
	logic signed [NXT_W-1:0]  nxt;
	logic [ccst_pkg::SOC_W-1:0] tick_soc;
	logic [ccst_pkg::SOC_W-1:0] load_soc;

	assign diff  = $signed({1'b0, BASE_W'(sum)}) - $signed({1'b0, BASE_W'(zero_sum)});
	assign prod  = diff * $signed({1'b0, gain});
	assign delta = DLT_W'(prod >>> 16);
	assign nxt   = $signed({{(NXT_W-ccst_pkg::SOC_W){1'b0}}, soc_q}) - NXT_W'(delta);

	always_comb begin
		if (nxt < 0) begin
			tick_soc = '0;
		end else if (nxt > $signed(NXT_W'(ccst_pkg::SOC_ONE))) begin
			tick_soc = ccst_pkg::SOC_ONE;
		end else begin
			tick_soc = nxt[ccst_pkg::SOC_W-1:0];
		end
	end

	assign load_soc = (load_value > ccst_pkg::SOC_ONE) ? ccst_pkg::SOC_ONE : load_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soc_q <= '0;
		end else if (step.tick_en) begin
			soc_q <= tick_soc;
		end else if (step.load_en) begin
			soc_q <= load_soc;
		end
	end

endmodule

@@ rtl/ccst_checker.sv @@
// Port-level checks for the SOC tracker, bound to the top level.
// Depends on ccst_pkg (SOC_W, SOC_ONE) and the top level's ports.
module ccst_checker #(
	parameter int WINDOW_DEPTH = 256,
	parameter int SAMPLE_BITS  = 12
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((ccst_pkg::SOC_W + SAMPLE_BITS + $clog2(WINDOW_DEPTH) + 1 + 7) / 8) * 8 - 1:0]
		m_tdata
);

	localparam int FILL_BIT = ccst_pkg::SOC_W + SAMPLE_BITS + $clog2(WINDOW_DEPTH);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ccst_pkg::SOC_W-1:0] <= ccst_pkg::SOC_ONE)
		else $error("soc_now above 1.0");

	a_filled_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[FILL_BIT] |=> !m_tvalid || m_tdata[FILL_BIT])
		else $error("window_filled dropped");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing two cycles after request");

endmodule

bind coulomb_counting_soc_tracker_top ccst_checker #(
	.WINDOW_DEPTH (WINDOW_DEPTH),
	.SAMPLE_BITS  (SAMPLE_BITS)
) u_ccst_checker (.*);

@@ sim/ccst_result_monitor.sv @@
// Result monitor for the coulomb-counting SOC tracker: mirrors ring, window sum
// and SOC from accepted requests and config writes, then checks every result.
// Depends on ccst_pkg; instantiated by tb_top beside the tracker.
`timescale 1ns / 100ps
module ccst_result_monitor #(
	parameter int S_W = 48,
	parameter int M_W = 56
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [S_W-1:0] s_tdata,
	input  logic [1:0] s_tuser,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [M_W-1:0] m_tdata,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [ccst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccst_pkg::CFG_DATA_W-1:0] cfg_data,
	output int mismatches,
	output int reports_due
);

	localparam int RING_DEPTH = 256;

	// packed from the top down, so soc_now lands in the lowest bits
	typedef struct packed {
		logic                       window_filled;
		logic [19:0]                window_total;
		logic [ccst_pkg::SOC_W-1:0] soc_now;
	} soc_report_t;

	logic [11:0]                 ring_codes [RING_DEPTH];
	logic [7:0]                  ring_ptr;
	logic [19:0]                 window_sum;
	logic                        ring_wrapped;
	logic [ccst_pkg::SOC_W-1:0]  charge;
	logic [ccst_pkg::ZERO_W-1:0] zero_ref;
	logic [ccst_pkg::GAIN_W-1:0] gain;
	soc_report_t                 expected_reports [$];

	function automatic logic [ccst_pkg::SOC_W-1:0] ticked_charge();
		longint diff;
		longint nxt;
		diff = longint'(window_sum) - longint'(zero_ref);
		nxt = longint'(charge) - ((diff * longint'(gain)) >>> 16);
		if (nxt < 0)
			nxt = 0;
		if (nxt > longint'(ccst_pkg::SOC_ONE))
			nxt = longint'(ccst_pkg::SOC_ONE);
		return nxt[ccst_pkg::SOC_W-1:0];
	endfunction

	function automatic logic [ccst_pkg::SOC_W-1:0] loaded_charge(
			input logic [ccst_pkg::SOC_W-1:0] level);
		return (level > ccst_pkg::SOC_ONE) ? ccst_pkg::SOC_ONE : level;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		soc_report_t seen;
		soc_report_t want;
		logic [11:0] code;
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++)
				ring_codes[i] = '0;
			ring_ptr = '0;
			window_sum = '0;
			ring_wrapped = 1'b0;
			charge = '0;
			zero_ref = ccst_pkg::ZERO_SUM_RST;
			gain = ccst_pkg::SOC_GAIN_RST;
			expected_reports.delete();
			mismatches = 0;
			reports_due = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata[$bits(soc_report_t)-1:0];
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: result with no request, soc %0d total %0d filled %0d",
							seen.soc_now, seen.window_total, seen.window_filled);
				end else begin
					want = expected_reports.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: soc %0d/%0d total %0d/%0d filled %0d/%0d (exp/act)",
								want.soc_now, seen.soc_now, want.window_total,
								seen.window_total, want.window_filled, seen.window_filled);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ccst_pkg::REG_ZERO_SUM: zero_ref = cfg_data[ccst_pkg::ZERO_W-1:0];
					ccst_pkg::REG_SOC_GAIN: gain = cfg_data[ccst_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					ccst_pkg::OP_SAMPLE: begin
						code = s_tdata[11:0];
						window_sum = window_sum - 20'(ring_codes[ring_ptr]) + 20'(code);
						ring_codes[ring_ptr] = code;
						ring_ptr = ring_ptr + 8'd1;
						if (ring_ptr == '0)
							ring_wrapped = 1'b1;
					end
					ccst_pkg::OP_TICK: charge = ticked_charge();
					ccst_pkg::OP_LOAD: charge = loaded_charge(s_tdata[12 +: ccst_pkg::SOC_W]);
					default: ;
				endcase
				want.soc_now = charge;
				want.window_total = window_sum;
				want.window_filled = ring_wrapped;
				expected_reports.push_back(want);
			end
			reports_due = expected_reports.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for coulomb_counting_soc_tracker_top: clock, reset, request and
// config stimulus, result backpressure, watchdog and verdict.
// Depends on ccst_pkg, the tracker RTL and ccst_result_monitor.
`timescale 1ns / 100ps
module tb_top;

	localparam int SOC_BITS = ccst_pkg::SOC_W;
	localparam int IDX_BITS = ccst_pkg::CFG_IDX_W;
	localparam int CFG_BITS = ccst_pkg::CFG_DATA_W;
	localparam int S_W = ((12 + SOC_BITS + 7) / 8) * 8;
	localparam int M_W = ((SOC_BITS + 12 + 8 + 1 + 7) / 8) * 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_SPARE_B = 2'd3;
	localparam logic [SOC_BITS-1:0] SOC_ONE = ccst_pkg::SOC_ONE;
	localparam int PHASE_ITEMS = 130;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	int mismatches;
	int reports_due;
	bit steady;
	int quiet_cycles;
	int sent [4];
	int cfg_writes;

	coulomb_counting_soc_tracker_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ccst_result_monitor #(.S_W(S_W), .M_W(M_W)) u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.reports_due(reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= steady || ($urandom_range(0, 99) >= 33);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("coulomb_counting_soc_tracker_top regression: fail");
					$finish;
				end
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input logic [1:0] op, input logic [11:0] code,
			input logic [SOC_BITS-1:0] level);
		while (!steady && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_W - 12 - SOC_BITS){1'b0}}, level, code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		sent[op]++;
	endtask

	task automatic random_request();
		int r;
		int k;
		logic [1:0] op;
		logic [11:0] code;
		logic [SOC_BITS-1:0] level;
		r = $urandom_range(0, 99);
		if (r < 58)
			op = ccst_pkg::OP_SAMPLE;
		else if (r < 78)
			op = ccst_pkg::OP_TICK;
		else if (r < 92)
			op = ccst_pkg::OP_LOAD;
		else
			op = OP_UNUSED;
		k = $urandom_range(0, 9);
		if (k == 0)
			code = 12'd0;
		else if (k == 1)
			code = 12'hFFF;
		else if (k < 5)
			code = 12'(3213 + $urandom_range(0, 400));
		else
			code = 12'($urandom);
		k = $urandom_range(0, 9);
		if (k == 0)
			level = '0;
		else if (k == 1)
			level = SOC_ONE;
		else if (k == 2)
			level = SOC_BITS'($urandom);
		else
			level = SOC_BITS'($urandom_range(0, 32'h4000_0000));
		send_request(op, code, level);
	endtask

	// register writes only with the tracker drained
	task automatic write_reg(input logic [IDX_BITS-1:0] index,
			input logic [CFG_BITS-1:0] value);
		s_tvalid <= 1'b0;
		while (reports_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		quiet_cycles = 0;
		cfg_writes = 0;
		foreach (sent[i])
			sent[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty window, extremes, saturation, unused op
		send_request(ccst_pkg::OP_TICK, 12'd0, '0);
		send_request(ccst_pkg::OP_SAMPLE, 12'hFFF, 31'h7FFF_FFFF);
		send_request(ccst_pkg::OP_SAMPLE, 12'd0, '0);
		send_request(ccst_pkg::OP_LOAD, 12'd0, '0);
		send_request(ccst_pkg::OP_TICK, 12'hFFF, 31'h7FFF_FFFF);
		send_request(ccst_pkg::OP_LOAD, 12'd0, SOC_ONE);
		send_request(ccst_pkg::OP_LOAD, 12'd0, 31'h7FFF_FFFF);
		send_request(ccst_pkg::OP_LOAD, 12'd0, SOC_ONE + 31'd1);
		send_request(ccst_pkg::OP_LOAD, 12'hFFF, 31'd1);
		send_request(OP_UNUSED, 12'hFFF, 31'h7FFF_FFFF);
		send_request(OP_UNUSED, 12'd0, '0);
		send_request(ccst_pkg::OP_SAMPLE, 12'hFFF, '0);
		send_request(ccst_pkg::OP_LOAD, 12'd0, 31'h2000_0000);
		send_request(ccst_pkg::OP_TICK, 12'd0, '0);
		send_request(ccst_pkg::OP_SAMPLE, 12'd3413, '0);
		send_request(ccst_pkg::OP_TICK, 12'd0, '0);
		send_request(ccst_pkg::OP_LOAD, 12'd0, SOC_ONE);
		send_request(ccst_pkg::OP_TICK, 12'd0, '0);

		repeat (PHASE_ITEMS) random_request();

		write_reg(ccst_pkg::REG_ZERO_SUM, '0);
		write_reg(ccst_pkg::REG_SOC_GAIN, '0);
		repeat (PHASE_ITEMS) random_request();

		steady <= 1'b1;
		write_reg(ccst_pkg::REG_ZERO_SUM, 24'hFF_FFFF);
		write_reg(ccst_pkg::REG_SOC_GAIN, 24'hFF_FFFF);
		repeat (PHASE_ITEMS) random_request();
		steady <= 1'b0;

		write_reg(REG_SPARE_A, CFG_BITS'($urandom));
		write_reg(REG_SPARE_B, CFG_BITS'($urandom));
		write_reg(ccst_pkg::REG_ZERO_SUM, 24'd1048320);
		write_reg(ccst_pkg::REG_SOC_GAIN, CFG_BITS'($urandom_range(0, 4095)));
		repeat (PHASE_ITEMS) random_request();

		write_reg(ccst_pkg::REG_ZERO_SUM, CFG_BITS'($urandom_range(800000, 900000)));
		write_reg(ccst_pkg::REG_SOC_GAIN, CFG_BITS'($urandom));
		repeat (PHASE_ITEMS) random_request();

		s_tvalid <= 1'b0;
		while (reports_due != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("covered %0d samples, %0d ticks, %0d SOC loads, %0d unused-op requests",
			sent[ccst_pkg::OP_SAMPLE], sent[ccst_pkg::OP_TICK], sent[ccst_pkg::OP_LOAD],
			sent[OP_UNUSED]);
		$display("%0d register writes, incl. out-of-range indexes and both gain/zero extremes",
			cfg_writes);
		if (mismatches == 0 && reports_due == 0)
			$display("coulomb_counting_soc_tracker_top regression: pass");
		else
			$display("coulomb_counting_soc_tracker_top regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ccst_pkg.sv
rtl/ccst_ring.sv
rtl/ccst_charge.sv
rtl/coulomb_counting_soc_tracker_top.sv
rtl/ccst_checker.sv
sim/ccst_result_monitor.sv
sim/tb_top.sv
